### rtl/core/xsdint_pkg.sv
// shared types and constants of the decimal integer literal parser
package xsdint_pkg;

  localparam int unsigned QDEPTH = 2;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned STATUS_W    = 2;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  localparam logic [3:0] DIGIT_BASE = 4'd10;
  localparam logic [31:0] MUL_LIMIT = 32'd214748364;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_RANGE     = 2'd2
  } status_e;

  typedef struct packed {
    logic       last;
    logic       is_ws;
    logic       is_plus;
    logic       is_minus;
    logic       is_digit;
    logic [3:0] digit;
  } byte_class_t;

endpackage

### rtl/core/xsdint_front.sv
// front end: accepts literal bytes and classifies them
module xsdint_front import xsdint_pkg::*; (
  input  logic                  in_valid_i,
  input  logic [7:0]            char_byte_i,
  input  logic                  last_byte_i,
  output logic                  in_ready_o,
  output logic                  cls_valid_o,
  output byte_class_t           cls_o,
  input  logic                  cls_ready_i
);

  logic [7:0] diff;

  assign diff = char_byte_i - CHAR_ZERO;

  always_comb begin
    cls_o.last     = last_byte_i;
    cls_o.is_ws    = (char_byte_i == CHAR_SPACE) || (char_byte_i == CHAR_TAB) ||
                     (char_byte_i == CHAR_CR) || (char_byte_i == CHAR_LF);
    cls_o.is_plus  = (char_byte_i == CHAR_PLUS);
    cls_o.is_minus = (char_byte_i == CHAR_MINUS);
    cls_o.is_digit = (diff < {4'd0, DIGIT_BASE});
    cls_o.digit    = diff[3:0];
  end

  assign cls_valid_o = in_valid_i;
  assign in_ready_o  = cls_ready_i;

endmodule

### rtl/core/xsdint_queue.sv
// short queue of classified bytes between front and back end
module xsdint_queue import xsdint_pkg::*; #(
  parameter int unsigned Depth = QDEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  input  byte_class_t push_data_i,
  output logic        push_ready_o,
  output logic        pop_valid_o,
  output byte_class_t pop_data_o,
  input  logic        pop_ready_i,
  output logic        full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  byte_class_t         mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                push, pop;

  assign full_o       = (count_q == CntW'(Depth));
  assign push_ready_o = !full_o;
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/core/xsdint_back.sv
// back end: scan state, digit accumulation, range check and result register
module xsdint_back import xsdint_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cls_valid_i,
  input  byte_class_t         cls_i,
  output logic                cls_ready_o,
  output logic                res_valid_o,
  output logic [VALUE_W-1:0]  res_value_o,
  output status_e             res_status_o,
  input  logic                res_ready_i
);

  localparam logic [1:0] PH_LEAD  = 2'd0;
  localparam logic [1:0] PH_SIGN  = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;
  localparam logic [1:0] PH_TRAIL = 2'd3;

  logic [1:0]         phase_q, phase_d;
  logic [31:0]        acc_q, acc_d;
  logic               neg_q, neg_d;
  status_e            err_q, err_d;

  logic               res_valid_q;
  logic [31:0]        res_mag_q;
  logic               res_neg_q;
  status_e            res_status_q;

  logic               pop, out_free, take;
  logic [31:0]        acc_next;
  logic               over;
  status_e            fin_status;

  assign out_free    = !res_valid_q || res_ready_i;
  assign cls_ready_o = !cls_i.last || out_free;
  assign pop         = cls_valid_i && cls_ready_o;
  assign acc_next    = (acc_q << 3) + (acc_q << 1) + {28'd0, cls_i.digit};

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    err_d   = err_q;
    take    = 1'b0;
    if (err_q == ST_OK) begin
      unique case (phase_q)
        PH_LEAD: begin
          if (cls_i.is_ws) begin
            phase_d = PH_LEAD;
          end else if (cls_i.is_minus) begin
            neg_d   = 1'b1;
            phase_d = PH_SIGN;
          end else if (cls_i.is_plus) begin
            phase_d = PH_SIGN;
          end else if (cls_i.is_digit) begin
            take = 1'b1;
          end else begin
            err_d = ST_MALFORMED;
          end
        end
        PH_SIGN: begin
          if (cls_i.is_digit) begin
            take = 1'b1;
          end else begin
            err_d = ST_MALFORMED;
          end
        end
        PH_DIGIT: begin
          if (cls_i.is_digit) begin
            take = 1'b1;
          end else if (cls_i.is_ws) begin
            phase_d = PH_TRAIL;
          end else begin
            err_d = ST_MALFORMED;
          end
        end
        default: begin
          if (!cls_i.is_ws) begin
            err_d = ST_MALFORMED;
          end
        end
      endcase
      if (take) begin
        if (acc_q > MUL_LIMIT) begin
          err_d = ST_RANGE;
          take  = 1'b0;
        end else begin
          acc_d   = acc_next;
          phase_d = PH_DIGIT;
        end
      end
    end
  end

  // final bound: a digit taken at the limit decides on its own value
  always_comb begin
    if (take) begin
      over = (acc_q == MUL_LIMIT) &&
             (neg_d ? (cls_i.digit > 4'd8) : (cls_i.digit > 4'd7));
    end else begin
      over = neg_d ? (acc_q[31] && (|acc_q[30:0])) : acc_q[31];
    end
    fin_status = err_d;
    if (err_d == ST_OK) begin
      if ((phase_d == PH_LEAD) || (phase_d == PH_SIGN)) begin
        fin_status = ST_MALFORMED;
      end else if (over) begin
        fin_status = ST_RANGE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEAD;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      err_q       <= ST_OK;
      res_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        if (cls_i.last) begin
          phase_q <= PH_LEAD;
          acc_q   <= '0;
          neg_q   <= 1'b0;
          err_q   <= ST_OK;
        end else begin
          phase_q <= phase_d;
          acc_q   <= acc_d;
          neg_q   <= neg_d;
          err_q   <= err_d;
        end
      end
      if (pop && cls_i.last) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && cls_i.last) begin
      res_status_q <= fin_status;
      res_mag_q    <= (fin_status == ST_OK) ? acc_d : '0;
      res_neg_q    <= neg_d && (fin_status == ST_OK);
    end
  end

  assign res_valid_o  = res_valid_q;
  assign res_value_o  = res_neg_q ? (32'd0 - res_mag_q) : res_mag_q;
  assign res_status_o = res_status_q;

endmodule

### rtl/core/xsd_int_literal_parser_core.sv
// top level of the decimal integer literal parser
//
//  channel  | direction | tdata                           | tlast
//  s_axis   | in        | [7:0] char_byte                 | last_byte
//  m_axis   | out       | [31:0] value, [33:32] status    | -
//
// one byte item per cycle sustained unless a final byte waits on a stalled output; the back end
// consumes one queued byte each cycle through a single multiply-by-ten and add
// a final byte reaches its result through the queue and then the result register
// reset clears the scan state, empties the queue and clears the result valid flag
// an output stall holds only final bytes; bytes behind a held final byte collect in the queue until it is full
module xsd_int_literal_parser_core import xsdint_pkg::*; #(
  parameter int unsigned QueueDepth = QDEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // [7:0] char_byte
  input  logic                   s_axis_tlast_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o   // [31:0] value, [33:32] status, zero pad
);

  logic                cls_valid, cls_ready;
  byte_class_t         cls;
  logic                q_valid, q_ready, q_full;
  byte_class_t         q_data;
  logic [VALUE_W-1:0]  res_value;
  status_e             res_status;

  xsdint_front u_front (
    .in_valid_i  (s_axis_tvalid_i),
    .char_byte_i (s_axis_tdata_i[7:0]),
    .last_byte_i (s_axis_tlast_i),
    .in_ready_o  (s_axis_tready_o),
    .cls_valid_o (cls_valid),
    .cls_o       (cls),
    .cls_ready_i (cls_ready)
  );

  xsdint_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cls_valid),
    .push_data_i  (cls),
    .push_ready_o (cls_ready),
    .pop_valid_o  (q_valid),
    .pop_data_o   (q_data),
    .pop_ready_i  (q_ready),
    .full_o       (q_full)
  );

  xsdint_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cls_valid_i  (q_valid),
    .cls_i        (q_data),
    .cls_ready_o  (q_ready),
    .res_valid_o  (m_axis_tvalid_o),
    .res_value_o  (res_value),
    .res_status_o (res_status),
    .res_ready_i  (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {6'd0, res_status, res_value};

  // an error result carries a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (res_status != ST_OK) |-> (res_value == '0))
    else $error("error result with nonzero value");

  // status never takes the unused code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((res_status == ST_OK) || (res_status == ST_MALFORMED) ||
                         (res_status == ST_RANGE)))
    else $error("unused status code on output");

  // input back-pressure only when the queue is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> q_full)
    else $error("input stalled with room in queue");

  // a stalled result is not overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("stalled result changed");

endmodule
